// ----- hw/rtl/point_segment_distance_top_assert.svh -----
// Assertion macros used by the checker of the point to segment distance block.
`ifndef POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("point_segment_distance check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("point_segment_distance check failed");

`endif

// ----- hw/rtl/psd_pkg.sv -----
// Package with widths, codes and word types of the point to segment distance block.
`timescale 1ns / 1ps
package psd_pkg;
	localparam int CW = 32;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 2;
	localparam int DENW = PW;
	localparam int XW = PW + DW;
	localparam int QW = DW;
	localparam int RW = PW;
	localparam int RTW = SW / 2;
	localparam int RMW = RTW + 3;

	localparam logic [1:0] SEL_A = 2'd0;
	localparam logic [1:0] SEL_B = 2'd1;
	localparam logic [1:0] SEL_MID = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] start_z;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic signed [CW-1:0] end_z;
	} in_word_t;

	typedef struct packed {
		logic [CW-1:0] distance;
		logic signed [CW-1:0] closest_x;
		logic signed [CW-1:0] closest_y;
		logic signed [CW-1:0] closest_z;
	} out_word_t;

	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;

	typedef struct packed {
		logic [1:0] sel;
		logic [2:0][CW-1:0] a;
		logic [2:0][CW-1:0] b;
		logic [2:0][CW-1:0] p;
		logic [2:0] dneg;
		logic [DENW-1:0] den;
	} side_t;

	typedef struct packed {
		logic [2:0][XW-1:0] x;
		side_t side;
	} div_in_t;

	typedef struct packed {
		logic [2:0][QW-1:0] q;
		logic [2:0][RW-1:0] r;
		side_t side;
	} div_out_t;

	typedef struct packed {
		logic [RTW-1:0] root;
		logic [RMW-1:0] rem;
		logic [2:0][CW-1:0] cl;
	} root_out_t;
endpackage

// ----- hw/rtl/psd_front.sv -----
// Front stages: differences, dot products, clamping decision and numerator products.
`timescale 1ns / 1ps
module psd_front (
	input logic clk,
	input logic arst_n,
	input psd_pkg::pipe_ctl_t ctl,
	input psd_pkg::in_word_t src,
	output logic dst_valid,
	output psd_pkg::div_in_t dst
);
	localparam int CW = psd_pkg::CW;
	localparam int DW = psd_pkg::DW;
	localparam int PW = psd_pkg::PW;
	localparam int SW = psd_pkg::SW;
	localparam int DENW = psd_pkg::DENW;
	localparam int XW = psd_pkg::XW;

	logic [2:0][CW-1:0] pin, ain, bin;
	assign pin = {src.point_z, src.point_y, src.point_x};
	assign ain = {src.start_z, src.start_y, src.start_x};
	assign bin = {src.end_z, src.end_y, src.end_x};

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [2:0][CW-1:0] a_s1, b_s1, p_s1, a_s2, b_s2, p_s2, a_s3, b_s3, p_s3;
	logic [2:0][DW-1:0] c_s1, d_s1, m_s2, m_s3;
	logic [2:0] dneg_s2, dneg_s3;
	logic [2:0][PW-1:0] dd_s2, cd_s2, lo_s4, hi_s4;
	logic [DENW-1:0] den_s3;
	logic [SW-1:0] dot_s3;
	psd_pkg::side_t side_s4;
	psd_pkg::div_in_t word_s5;

	logic signed [PW-1:0] dd_c [3];
	logic signed [PW-1:0] cd_c [3];
	logic [DW-1:0] m_c [3];
	logic signed [SW-1:0] dot_c;
	logic [DENW-1:0] den_c;
	logic [PW-1:0] lo_c [3];
	logic [PW-1:0] hi_c [3];
	logic [1:0] sel_c;
	logic pos_c, ge_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dd_c[i] = $signed(d_s1[i]) * $signed(d_s1[i]);
			cd_c[i] = $signed(c_s1[i]) * $signed(d_s1[i]);
			m_c[i] = d_s1[i][DW-1] ? (~d_s1[i] + 1'b1) : d_s1[i];
		end
	end

	always_comb begin
		den_c = dd_s2[0] + dd_s2[1] + dd_s2[2];
		dot_c = $signed(cd_s2[0]) + $signed(cd_s2[1]) + $signed(cd_s2[2]);
	end

	always_comb begin
		pos_c = !dot_s3[SW-1] && (dot_s3 != '0);
		ge_c = dot_s3 >= {{(SW-DENW){1'b0}}, den_s3};
		if (den_s3 == '0 || !pos_c) begin
			sel_c = psd_pkg::SEL_A;
		end else if (ge_c) begin
			sel_c = psd_pkg::SEL_B;
		end else begin
			sel_c = psd_pkg::SEL_MID;
		end
		for (int i = 0; i < 3; i++) begin
			lo_c[i] = dot_s3[DW-1:0] * m_s3[i];
			hi_c[i] = dot_s3[2*DW-1:DW] * m_s3[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= ctl.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 3; i++) begin
				c_s1[i] <= {pin[i][CW-1], pin[i]} - {ain[i][CW-1], ain[i]};
				d_s1[i] <= {bin[i][CW-1], bin[i]} - {ain[i][CW-1], ain[i]};
				dd_s2[i] <= dd_c[i];
				cd_s2[i] <= cd_c[i];
				m_s2[i] <= m_c[i];
				dneg_s2[i] <= d_s1[i][DW-1];
				lo_s4[i] <= lo_c[i];
				hi_s4[i] <= hi_c[i];
				word_s5.x[i] <= {hi_s4[i], {DW{1'b0}}} + {{(XW-PW){1'b0}}, lo_s4[i]};
			end
			a_s1 <= ain;
			b_s1 <= bin;
			p_s1 <= pin;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			p_s2 <= p_s1;
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			p_s3 <= p_s2;
			m_s3 <= m_s2;
			dneg_s3 <= dneg_s2;
			den_s3 <= den_c;
			dot_s3 <= dot_c;
			side_s4.sel <= sel_c;
			side_s4.a <= a_s3;
			side_s4.b <= b_s3;
			side_s4.p <= p_s3;
			side_s4.dneg <= dneg_s3;
			side_s4.den <= den_s3;
			word_s5.side <= side_s4;
		end
	end

	assign dst_valid = valid_s5;
	assign dst = word_s5;
endmodule

// ----- hw/rtl/psd_div.sv -----
// Divider pipeline: one quotient bit per stage for each of the three axes.
`timescale 1ns / 1ps
module psd_div (
	input logic clk,
	input logic arst_n,
	input psd_pkg::pipe_ctl_t ctl,
	input psd_pkg::div_in_t src,
	output logic dst_valid,
	output psd_pkg::div_out_t dst
);
	localparam int QW = psd_pkg::QW;
	localparam int RW = psd_pkg::RW;
	localparam int XW = psd_pkg::XW;

	typedef struct packed {
		logic [2:0][RW-1:0] r;
		logic [2:0][QW-1:0] q;
		logic [2:0][QW-1:0] xl;
		psd_pkg::side_t side;
	} dstage_t;

	dstage_t st_s [QW];
	logic vld_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_bit
		dstage_t cur, nxt;
		logic vin;

		if (k == 0) begin : g_head
			always_comb begin
				cur.side = src.side;
				for (int i = 0; i < 3; i++) begin
					cur.r[i] = src.x[i][XW-1:QW];
					cur.q[i] = '0;
					cur.xl[i] = src.x[i][QW-1:0];
				end
			end
			assign vin = ctl.valid;
		end else begin : g_body
			assign cur = st_s[k-1];
			assign vin = vld_s[k-1];
		end

		always_comb begin
			logic [RW:0] t;
			logic [RW:0] df;
			logic take;
			nxt = cur;
			for (int i = 0; i < 3; i++) begin
				t = {cur.r[i], cur.xl[i][QW-1]};
				df = t - {1'b0, cur.side.den};
				take = t >= {1'b0, cur.side.den};
				nxt.r[i] = take ? df[RW-1:0] : t[RW-1:0];
				nxt.q[i] = {cur.q[i][QW-2:0], take};
				nxt.xl[i] = {cur.xl[i][QW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign dst_valid = vld_s[QW-1];
	assign dst.q = st_s[QW-1].q;
	assign dst.r = st_s[QW-1].r;
	assign dst.side = st_s[QW-1].side;
endmodule

// ----- hw/rtl/psd_root.sv -----
// Closest point selection, squared distance and square root pipeline.
`timescale 1ns / 1ps
module psd_root (
	input logic clk,
	input logic arst_n,
	input psd_pkg::pipe_ctl_t ctl,
	input psd_pkg::div_out_t src,
	output logic dst_valid,
	output psd_pkg::root_out_t dst
);
	localparam int CW = psd_pkg::CW;
	localparam int DW = psd_pkg::DW;
	localparam int PW = psd_pkg::PW;
	localparam int SW = psd_pkg::SW;
	localparam int QW = psd_pkg::QW;
	localparam int RTW = psd_pkg::RTW;
	localparam int RMW = psd_pkg::RMW;

	typedef struct packed {
		logic [RTW-1:0] root;
		logic [RMW-1:0] rem;
		logic [SW-1:0] rad;
		logic [2:0][CW-1:0] cl;
	} rstage_t;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2:0][CW-1:0] cl_s1, cl_s2, cl_s3, cl_s4, p_s1;
	logic [2:0][DW-1:0] e_s2;
	logic [2:0][PW-1:0] sq_s3;
	logic [SW-1:0] sum_s4;
	logic [2:0][CW-1:0] cl_c;
	logic signed [PW-1:0] sq_c [3];

	always_comb begin
		logic up;
		logic [QW-1:0] qr;
		logic [CW-1:0] mid;
		for (int i = 0; i < 3; i++) begin
			up = {src.r[i], 1'b0} >= {1'b0, src.side.den};
			qr = src.q[i] + {{(QW-1){1'b0}}, up};
			mid = src.side.dneg[i] ? (src.side.a[i] - qr[CW-1:0])
				: (src.side.a[i] + qr[CW-1:0]);
			unique case (src.side.sel)
				psd_pkg::SEL_A: cl_c[i] = src.side.a[i];
				psd_pkg::SEL_B: cl_c[i] = src.side.b[i];
				psd_pkg::SEL_MID: cl_c[i] = mid;
				default: cl_c[i] = src.side.a[i];
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = $signed(e_s2[i]) * $signed(e_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= ctl.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			cl_s1 <= cl_c;
			p_s1 <= src.side.p;
			for (int i = 0; i < 3; i++) begin
				e_s2[i] <= {cl_s1[i][CW-1], cl_s1[i]} - {p_s1[i][CW-1], p_s1[i]};
				sq_s3[i] <= sq_c[i];
			end
			cl_s2 <= cl_s1;
			cl_s3 <= cl_s2;
			cl_s4 <= cl_s3;
			sum_s4 <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
		end
	end

	rstage_t st_s [RTW];
	logic vld_s [RTW];

	for (genvar k = 0; k < RTW; k++) begin : g_digit
		rstage_t cur, nxt;
		logic vin;

		if (k == 0) begin : g_head
			always_comb begin
				cur.root = '0;
				cur.rem = '0;
				cur.rad = sum_s4;
				cur.cl = cl_s4;
			end
			assign vin = valid_s4;
		end else begin : g_body
			assign cur = st_s[k-1];
			assign vin = vld_s[k-1];
		end

		always_comb begin
			logic [RMW-1:0] t;
			logic [RMW-1:0] trial;
			nxt = cur;
			t = {cur.rem[RMW-3:0], cur.rad[SW-1:SW-2]};
			trial = {{(RMW-RTW-2){1'b0}}, cur.root, 2'b01};
			if (t >= trial) begin
				nxt.rem = t - trial;
				nxt.root = {cur.root[RTW-2:0], 1'b1};
			end else begin
				nxt.rem = t;
				nxt.root = {cur.root[RTW-2:0], 1'b0};
			end
			nxt.rad = {cur.rad[SW-3:0], 2'b00};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign dst_valid = vld_s[RTW-1];
	assign dst.root = st_s[RTW-1].root;
	assign dst.rem = st_s[RTW-1].rem;
	assign dst.cl = st_s[RTW-1].cl;
endmodule

// ----- hw/rtl/point_segment_distance_top.sv -----
// Top level of the point to segment distance block.
// The block takes one word per cycle while pt_stall is low and returns one result word
// per accepted word through five front stages, a divider that settles one quotient bit
// per stage (33), four stages for the closest point and squared distance, a square root
// that settles one root bit per stage (34) and the output register. A one-word skid stage
// behind the output register keeps the pipeline running while a result waits; pt_stall is
// high only while that skid stage holds a word.
`timescale 1ns / 1ps
module point_segment_distance_top (
	input logic clk,
	input logic arst_n,
	input logic pt_valid,
	output logic pt_stall,
	input psd_pkg::in_word_t pt_word,
	output logic res_valid,
	input logic res_stall,
	output psd_pkg::out_word_t res_word
);
	localparam int CW = psd_pkg::CW;
	localparam int RTW = psd_pkg::RTW;
	localparam int RMW = psd_pkg::RMW;

	logic en;
	logic front_valid, div_valid, root_valid;
	psd_pkg::div_in_t front_word;
	psd_pkg::div_out_t div_word;
	psd_pkg::root_out_t root_word;
	psd_pkg::pipe_ctl_t front_ctl, div_ctl, root_ctl;
	psd_pkg::out_word_t res_c, out_q, skid_q;
	logic valid_q, skv_q;

	assign en = !skv_q;
	assign pt_stall = skv_q;
	assign front_ctl = '{en: en, valid: pt_valid};
	assign div_ctl = '{en: en, valid: front_valid};
	assign root_ctl = '{en: en, valid: div_valid};

	psd_front u_front (
		.clk(clk), .arst_n(arst_n), .ctl(front_ctl), .src(pt_word),
		.dst_valid(front_valid), .dst(front_word)
	);

	psd_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .src(front_word),
		.dst_valid(div_valid), .dst(div_word)
	);

	psd_root u_root (
		.clk(clk), .arst_n(arst_n), .ctl(root_ctl), .src(div_word),
		.dst_valid(root_valid), .dst(root_word)
	);

	always_comb begin
		logic up;
		logic [RTW:0] sr;
		up = root_word.rem > {{(RMW-RTW){1'b0}}, root_word.root};
		sr = {1'b0, root_word.root} + {{RTW{1'b0}}, up};
		res_c.distance = (|sr[RTW:CW]) ? {CW{1'b1}} : sr[CW-1:0];
		res_c.closest_x = root_word.cl[0];
		res_c.closest_y = root_word.cl[1];
		res_c.closest_z = root_word.cl[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			skv_q <= 1'b0;
		end else if (!valid_q || !res_stall) begin
			if (skv_q) begin
				valid_q <= 1'b1;
				skv_q <= 1'b0;
			end else begin
				valid_q <= root_valid;
			end
		end else if (root_valid && en) begin
			skv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_q || !res_stall) begin
			out_q <= skv_q ? skid_q : res_c;
		end else if (root_valid && en) begin
			skid_q <= res_c;
		end
	end

	assign res_valid = valid_q;
	assign res_word = out_q;
endmodule

// ----- hw/rtl/psd_check.sv -----
// Port checker for the point to segment distance block and its bind.
`timescale 1ns / 1ps
`include "point_segment_distance_top_assert.svh"
module psd_check (
	input logic clk,
	input logic arst_n,
	input logic pt_stall,
	input logic res_valid,
	input logic res_stall,
	input psd_pkg::out_word_t res_word
);
	`PSD_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`PSD_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res_word))
	`PSD_ASSERT_NOW(a_stall_cause, $rose(pt_stall), $past(res_valid && res_stall))
	`PSD_ASSERT_NEXT(a_stall_clear, pt_stall && !res_stall, !pt_stall)
endmodule

bind point_segment_distance_top psd_check u_psd_check (.*);

// ----- dv/point_segment_distance_top_test.sv -----
// Testbench for the point to segment distance block: random and directed queries.
`timescale 1ns / 1ps
module point_segment_distance_top_test;
	localparam int N_RANDOM = 1350;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pt_valid;
	logic pt_stall;
	psd_pkg::in_word_t pt_word = '0;
	logic res_valid;
	logic res_stall;
	psd_pkg::out_word_t res_word;

	psd_pkg::in_word_t pending_queries[$];
	psd_pkg::out_word_t expected_results[$];
	int unsigned error_count = 0;
	int unsigned queries_sent = 0;
	int unsigned results_checked = 0;
	int unsigned send_gap;
	int unsigned stall_left;
	bit send_busy;
	bit recv_busy;
	bit stim_done = 1'b0;

	point_segment_distance_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt_word(pt_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word)
	);

	always #5 clk = ~clk;

	function automatic psd_pkg::out_word_t closest_on_segment(psd_pkg::in_word_t w);
		logic signed [127:0] p [3];
		logic signed [127:0] a [3];
		logic signed [127:0] b [3];
		logic signed [127:0] d [3];
		logic signed [127:0] cl [3];
		logic signed [127:0] dot, den, x, q, rem, e, sum, s, cand;
		psd_pkg::out_word_t r;
		int i;
		p[0] = w.point_x; p[1] = w.point_y; p[2] = w.point_z;
		a[0] = w.start_x; a[1] = w.start_y; a[2] = w.start_z;
		b[0] = w.end_x; b[1] = w.end_y; b[2] = w.end_z;
		dot = 0;
		den = 0;
		for (i = 0; i < 3; i++) begin
			d[i] = b[i] - a[i];
			den += d[i] * d[i];
			dot += (p[i] - a[i]) * d[i];
		end
		for (i = 0; i < 3; i++) begin
			if (den == 0 || dot <= 0) begin
				cl[i] = a[i];
			end else if (dot >= den) begin
				cl[i] = b[i];
			end else begin
				x = dot * (d[i] < 0 ? -d[i] : d[i]);
				q = x / den;
				rem = x % den;
				if (2 * rem >= den) q += 1;
				cl[i] = d[i] < 0 ? a[i] - q : a[i] + q;
			end
		end
		sum = 0;
		for (i = 0; i < 3; i++) begin
			e = cl[i] - p[i];
			sum += e * e;
		end
		s = 0;
		for (i = 52; i >= 0; i--) begin
			cand = s | (128'sd1 << i);
			if (cand * cand <= sum) s = cand;
		end
		if (sum > s * s + s) s += 1;
		if (s > 128'sh0FFFFFFFF) s = 128'sh0FFFFFFFF;
		r.distance = s[31:0];
		r.closest_x = cl[0][31:0];
		r.closest_y = cl[1][31:0];
		r.closest_z = cl[2][31:0];
		return r;
	endfunction

	function automatic logic [31:0] rand_coord(int unsigned mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
					: 32'h80000000 + $urandom_range(0, 3);
			2: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
			default: return $signed($urandom_range(0, 32'h00000040)) - 32'sh00000020;
		endcase
	endfunction

	task automatic add_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
			logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
		psd_pkg::in_word_t w;
		w.point_x = px; w.point_y = py; w.point_z = pz;
		w.start_x = ax; w.start_y = ay; w.start_z = az;
		w.end_x = bx; w.end_y = by; w.end_z = bz;
		pending_queries.push_back(w);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
			send_gap <= 0;
			send_busy <= 1'b1;
		end else begin
			if (pt_valid && !pt_stall) begin
				expected_results.push_back(closest_on_segment(pt_word));
				queries_sent++;
			end
			if (!pt_valid || !pt_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					pt_valid <= 1'b0;
				end else if (pending_queries.size() > 0) begin
					pt_word <= pending_queries.pop_front();
					pt_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0) send_busy <= ~send_busy;
					send_gap <= send_busy ? $urandom_range(0, 11) : 0;
				end else begin
					pt_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int unsigned n;
		psd_pkg::out_word_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
			recv_busy <= 1'b1;
		end else if (res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word distance", res_word.distance, '0);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (res_word.distance !== want.distance)
					report_mismatch("distance", res_word.distance, want.distance);
				if (res_word.closest_x !== want.closest_x)
					report_mismatch("closest_x", res_word.closest_x, want.closest_x);
				if (res_word.closest_y !== want.closest_y)
					report_mismatch("closest_y", res_word.closest_y, want.closest_y);
				if (res_word.closest_z !== want.closest_z)
					report_mismatch("closest_z", res_word.closest_z, want.closest_z);
			end
			if ($urandom_range(0, 39) == 0) recv_busy <= ~recv_busy;
			n = recv_busy ? $urandom_range(0, 11) : 0;
			stall_left <= n;
			res_stall <= (n != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= (stall_left > 1);
		end
	end

	initial begin
		int k;
		int unsigned m;
		logic [31:0] ax, ay, az, bx, by, bz;
		// All zero, zero-length segments and the full-scale corners.
		add_query(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_query(32'h00010000, 0, 0, 32'h00050000, 32'h00020000, 0,
			32'h00050000, 32'h00020000, 0);
		add_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		add_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		add_query(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		// Projection before the start, exactly at it, beyond the end and exactly at it.
		add_query(32'hFFFF0000, 32'h00010000, 0, 0, 0, 0, 32'h00040000, 0, 0);
		add_query(0, 32'h00030000, 0, 0, 0, 0, 32'h00040000, 0, 0);
		add_query(32'h00090000, 32'h00010000, 0, 0, 0, 0, 32'h00040000, 0, 0);
		add_query(32'h00040000, 32'hFFFD0000, 0, 0, 0, 0, 32'h00040000, 0, 0);
		// Interior projections, including ones that round on a tie, and one that clamps to the end.
		add_query(32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0,
			32'h00030000, 32'h00020000, 32'h00010000);
		add_query(1, 5, 0, 0, 0, 0, 2, 0, 0);
		add_query(1, 7, 3, 0, 0, 0, 3, 3, 0);
		add_query(3, 0, 0, 0, 0, 0, 4, 4, 0);
		add_query(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h80000000, 0,
			32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		add_query(0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0, 0,
			32'h7FFFFFFF, 0, 0);
		add_query(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hFFFF0000, 32'h00008000,
			32'h7FFF0000, 32'h00010000, 32'hFFFF8000, 32'h80010000);
		for (k = 0; k < N_RANDOM; k++) begin
			m = $urandom_range(0, 9);
			m = (m < 3) ? 0 : (m < 4) ? 1 : (m < 8) ? 2 : 3;
			ax = rand_coord(m); ay = rand_coord(m); az = rand_coord(m);
			case ($urandom_range(0, 9))
				0: begin bx = ax; by = ay; bz = az; end
				1: begin bx = ax; by = ay; bz = rand_coord(m); end
				default: begin bx = rand_coord(m); by = rand_coord(m); bz = rand_coord(m); end
			endcase
			add_query(rand_coord(m), rand_coord(m), rand_coord(m), ax, ay, az, bx, by, bz);
		end
		stim_done = 1'b1;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done);
		while (pending_queries.size() > 0 || pt_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() > 0) error_count++;
		$display("Sent %0d queries and checked %0d results, with random gaps on both sides.",
			queries_sent, results_checked);
		$display("Queries covered zero-length segments, both clamps, interior points and saturation.");
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("CHECK FAILED");
		$finish;
	end
endmodule
